### rtl/accel_magnitude_highpass_peak_counter_assert.svh
// Assertion macros used by the checker file of the peak counter.
`ifndef ACCEL_MAGNITUDE_HIGHPASS_PEAK_COUNTER_ASSERT_SVH
`define ACCEL_MAGNITUDE_HIGHPASS_PEAK_COUNTER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define AMHP_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("amhp assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define AMHP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("amhp assertion failed");

`endif

### rtl/amhp_pkg.sv
// Types and fixed constants of the accelerometer high-pass peak counter.
package amhp_pkg;

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
    } accel_in_t;

    typedef struct packed {
        logic signed [39:0] filtered_level;
        logic               detected;
        logic [31:0]        detection_count;
        logic [38:0]        last_strength;
    } peak_out_t;

    // Reciprocal of the input gain, scaled by 2^28.
    localparam logic [27:0] INV_GAIN_Q28    = 28'd143264695;
    localparam logic [38:0] THRESHOLD_RESET = 39'd36000000;

    // Feedback coefficients in Q2.28, oldest output first.
    localparam logic signed [30:0] COEF_A0 = -31'sd71891944;
    localparam logic signed [30:0] COEF_A1 = 31'sd391087475;
    localparam logic signed [30:0] COEF_A2 = -31'sd807845348;
    localparam logic signed [30:0] COEF_A3 = 31'sd752974892;

    localparam logic signed [55:0] Y_MAX = {1'b0, {55{1'b1}}};
    localparam logic signed [55:0] Y_MIN = {1'b1, {55{1'b0}}};

    // Sequencer steps.
    localparam logic [3:0] STEP_SQ_X       = 4'd0;
    localparam logic [3:0] STEP_SQ_Y       = 4'd1;
    localparam logic [3:0] STEP_SQ_Z       = 4'd2;
    localparam logic [3:0] STEP_FILT_FIRST = 4'd3;
    localparam logic [3:0] STEP_FILT_LAST  = 4'd10;
    localparam logic [3:0] STEP_GAIN       = 4'd11;
    localparam logic [3:0] STEP_XNEW       = 4'd12;
    localparam logic [3:0] STEP_XTERM      = 4'd13;
    localparam logic [3:0] STEP_X6         = 4'd14;
    localparam logic [3:0] STEP_DONE       = 4'd15;

    function automatic logic signed [30:0] coef_a(input logic [1:0] tap);
        logic signed [30:0] c;
        unique case (tap)
            2'd0:    c = COEF_A0;
            2'd1:    c = COEF_A1;
            2'd2:    c = COEF_A2;
            default: c = COEF_A3;
        endcase
        return c;
    endfunction

endpackage

### rtl/accel_magnitude_highpass_peak_counter.sv
// Accelerometer magnitude, fourth-order high-pass filter and threshold peak counter.
// One sample is taken at a time. A single 33x33 signed multiplier, run by a four-bit
// step counter, forms the three squares, the eight halves of the feedback products and
// the gain product; four more steps add the input taps, saturate and compare. A sample
// therefore runs through all the steps from acceptance to its result, and waits at the last step
// while a previous result still waits in the output register of the result channel; s_ready is
// low for the whole of that time. The threshold may be written whenever the block idles.
module accel_magnitude_highpass_peak_counter (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  amhp_pkg::accel_in_t   s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output amhp_pkg::peak_out_t   m_data,
    input  logic                  cfg_wr_en,
    input  logic [38:0]           cfg_wr_data
);
    import amhp_pkg::*;

    logic               busy_reg;
    logic [3:0]         step_reg;
    accel_in_t          sample_reg;
    logic signed [65:0] prod_reg;
    logic [31:0]        sum_reg;
    logic signed [63:0] hi_reg;
    logic signed [63:0] lo_reg;
    logic signed [63:0] acc_reg;
    logic [47:0]        xnew_reg;
    logic [47:0]        in_hist_reg  [4];
    logic signed [55:0] out_hist_reg [4];
    logic [31:0]        hit_count_reg;
    logic [39:0]        last_hit_reg;
    logic [38:0]        thresh_reg;
    logic               m_valid_reg;
    peak_out_t          m_data_reg;

    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] mul_p;
    logic [2:0]         filt_idx;
    logic [2:0]         acc_idx;
    logic signed [63:0] ih_ext [4];
    logic signed [63:0] lo_rnd;
    logic [59:0]        gain_rnd;
    logic signed [55:0] y_sat;
    logic signed [55:0] thresh_q16;
    logic               hit;
    logic               out_free;
    logic               result_load;

    assign s_ready  = aresetn && !busy_reg;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign out_free = !m_valid_reg || m_ready;

    // The finished sample moves into the output register in this cycle.
    assign result_load = busy_reg && (step_reg == STEP_DONE) && out_free;

    assign filt_idx = 3'(step_reg - STEP_FILT_FIRST);
    assign acc_idx  = 3'(step_reg - STEP_FILT_FIRST - 4'd1);

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (step_reg)
            STEP_SQ_X: begin
                mul_a = 33'(sample_reg.accel_x);
                mul_b = 33'(sample_reg.accel_x);
            end
            STEP_SQ_Y: begin
                mul_a = 33'(sample_reg.accel_y);
                mul_b = 33'(sample_reg.accel_y);
            end
            STEP_SQ_Z: begin
                mul_a = 33'(sample_reg.accel_z);
                mul_b = 33'(sample_reg.accel_z);
            end
            STEP_GAIN: begin
                mul_a = $signed({1'b0, sum_reg});
                mul_b = $signed({5'd0, INV_GAIN_Q28});
            end
            default: begin
                if (step_reg >= STEP_FILT_FIRST && step_reg <= STEP_FILT_LAST) begin
                    // Each past output is split into a signed high part and an
                    // unsigned 28-bit low part so both products stay exact.
                    if (filt_idx[0]) begin
                        mul_a = $signed({5'd0, out_hist_reg[filt_idx[2:1]][27:0]});
                    end else begin
                        mul_a = {{5{out_hist_reg[filt_idx[2:1]][55]}},
                                 out_hist_reg[filt_idx[2:1]][55:28]};
                    end
                    mul_b = 33'(coef_a(filt_idx[2:1]));
                end
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            ih_ext[i] = $signed({16'd0, in_hist_reg[i]});
        end
    end

    assign lo_rnd   = (lo_reg + 64'sd134217728) >>> 28;
    assign gain_rnd = prod_reg[59:0] + 60'd2048;

    always_comb begin
        if (acc_reg[63:55] == {9{acc_reg[63]}}) begin
            y_sat = acc_reg[55:0];
        end else if (acc_reg[63]) begin
            y_sat = Y_MIN;
        end else begin
            y_sat = Y_MAX;
        end
    end

    assign thresh_q16 = $signed({1'b0, thresh_reg, 16'd0});
    assign hit        = y_sat > thresh_q16;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            step_reg      <= STEP_SQ_X;
            m_valid_reg   <= 1'b0;
            hit_count_reg <= '0;
            last_hit_reg  <= '0;
            thresh_reg    <= THRESHOLD_RESET;
            for (int i = 0; i < 4; i++) begin
                in_hist_reg[i]  <= '0;
                out_hist_reg[i] <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                thresh_reg <= cfg_wr_data;
            end
            if (m_valid_reg && m_ready && !result_load) begin
                m_valid_reg <= 1'b0;
            end

            if (!busy_reg) begin
                if (s_valid) begin
                    busy_reg   <= 1'b1;
                    step_reg   <= STEP_SQ_X;
                    sample_reg <= s_data;
                    sum_reg    <= '0;
                    hi_reg     <= '0;
                    lo_reg     <= '0;
                end
            end else begin
                prod_reg <= mul_p;
                if (step_reg != STEP_DONE) begin
                    step_reg <= step_reg + 4'd1;
                end

                if (step_reg >= STEP_SQ_Y && step_reg <= STEP_FILT_FIRST) begin
                    sum_reg <= sum_reg + prod_reg[31:0];
                end
                if (step_reg > STEP_FILT_FIRST && step_reg <= STEP_GAIN) begin
                    if (acc_idx[0]) begin
                        lo_reg <= lo_reg + $signed(prod_reg[63:0]);
                    end else begin
                        hi_reg <= hi_reg + $signed(prod_reg[63:0]);
                    end
                end

                unique case (step_reg)
                    STEP_XNEW: begin
                        xnew_reg <= gain_rnd[59:12];
                        acc_reg  <= hi_reg + lo_rnd;
                    end
                    STEP_XTERM: begin
                        acc_reg <= acc_reg + $signed({16'd0, xnew_reg}) + ih_ext[0]
                                 - ((ih_ext[1] + ih_ext[3]) <<< 2);
                    end
                    STEP_X6: begin
                        acc_reg <= acc_reg + (ih_ext[2] <<< 2) + (ih_ext[2] <<< 1);
                    end
                    STEP_DONE: begin
                        // Hold here until the previous result has left.
                        if (out_free) begin
                            busy_reg    <= 1'b0;
                            m_valid_reg <= 1'b1;
                            for (int i = 0; i < 3; i++) begin
                                in_hist_reg[i]  <= in_hist_reg[i + 1];
                                out_hist_reg[i] <= out_hist_reg[i + 1];
                            end
                            in_hist_reg[3]  <= xnew_reg;
                            out_hist_reg[3] <= y_sat;
                            m_data_reg.filtered_level <= y_sat[55:16];
                            m_data_reg.detected       <= hit;
                            if (hit) begin
                                hit_count_reg <= hit_count_reg + 32'd1;
                                last_hit_reg  <= y_sat[55:16];
                                m_data_reg.detection_count <= hit_count_reg + 32'd1;
                                m_data_reg.last_strength   <= y_sat[54:16];
                            end else begin
                                m_data_reg.detection_count <= hit_count_reg;
                                m_data_reg.last_strength   <= last_hit_reg[38:0];
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

### rtl/amhp_checker.sv
// Port-level checker of the peak counter and its bind to the top level.
`include "accel_magnitude_highpass_peak_counter_assert.svh"

module amhp_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input amhp_pkg::peak_out_t  m_data
);
    import amhp_pkg::*;

    logic in_xfer;
    logic out_hit;
    logic hit_level_match;

    assign in_xfer         = s_valid && s_ready;
    assign out_hit         = m_valid && m_data.detected;
    assign hit_level_match = m_data.last_strength == m_data.filtered_level[38:0];

    // A stalled result keeps its contents.
    `AMHP_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))
    // One sample at a time: after a transfer in, the input side is closed.
    `AMHP_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, in_xfer, !s_ready)
    // A detection reports its own level as the last strength.
    `AMHP_ASSERT_NOW(a_hit_strength, aclk, aresetn, out_hit, hit_level_match)
    // A detection is never below zero, since the threshold is unsigned.
    `AMHP_ASSERT_NOW(a_hit_sign, aclk, aresetn, out_hit, !m_data.filtered_level[39])

endmodule

bind accel_magnitude_highpass_peak_counter amhp_checker u_amhp_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_data      (m_data)
);
